FILE: sv/hipr_pkg.sv
// Package for the heap image pointer relocator: shared types, field layout constants
// and register map codes. No dependencies.
package hipr_pkg;

    localparam int WORD_W     = 64;
    localparam int WORD_BYTES = 8;
    localparam int WORD_SHIFT = $clog2(WORD_BYTES);
    localparam int BYTES_W    = 30;
    localparam int PAY_W      = BYTES_W + 1 - WORD_SHIFT;
    localparam int COUNT_W    = 6;
    localparam int HASH_W     = 23;
    localparam int ADDR_W     = 4;

    localparam logic [HASH_W-1:0] HASH_RESERVED = 23'h7FFFF0;

    localparam logic [1:0] TYPE_PLAIN    = 2'd0;
    localparam logic [1:0] TYPE_OOP_ARR  = 2'd1;
    localparam logic [1:0] TYPE_BYTE_ARR = 2'd2;
    localparam logic [1:0] TYPE_PAY_HDR  = 2'd3;

    localparam logic REG_SHIFT = 1'b0;
    localparam logic REG_MARK  = 1'b1;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_MAP     = 2'd1,
        PH_SLOTS   = 2'd2,
        PH_PAYLOAD = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ROLE_PAY_HDR  = 3'd0,
        ROLE_OBJ_HDR  = 3'd1,
        ROLE_MAP      = 3'd2,
        ROLE_SLOT     = 3'd3,
        ROLE_OOP_ELEM = 3'd4,
        ROLE_BYTE     = 3'd5
    } role_t;

    typedef struct packed {
        logic [WORD_W-1:0] heap_word;
        logic              last_word;
    } item_t;

    typedef struct packed {
        logic [WORD_W-1:0] out_word;
        logic              was_adjusted;
        role_t             word_role;
        logic              size_error;
        logic              end_of_image;
    } result_t;

    typedef struct packed {
        logic [WORD_W-1:0] rebase_offset;
        logic              live_mark;
    } cfg_t;

endpackage

FILE: sv/hipr_cfg.sv
// Configuration registers of the relocator behind an APB-style port.
// Depends on hipr_pkg.
module hipr_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hipr_pkg::ADDR_W-1:0] paddr,
    input  logic [hipr_pkg::WORD_W-1:0] pwdata,
    output logic [hipr_pkg::WORD_W-1:0] prdata,
    output logic                        pready,
    output hipr_pkg::cfg_t              cfg
);

    logic [hipr_pkg::WORD_W-1:0] shift_reg;
    logic                        mark_reg;
    logic                        wr_en;
    logic                        reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = paddr[3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= '0;
            mark_reg  <= 1'b1;
        end else if (wr_en) begin
            if (reg_sel == hipr_pkg::REG_SHIFT) begin
                shift_reg <= pwdata;
            end else begin
                mark_reg <= pwdata[0];
            end
        end
    end

    always_comb begin
        if (reg_sel == hipr_pkg::REG_SHIFT) begin
            prdata = shift_reg;
        end else begin
            prdata = {{(hipr_pkg::WORD_W-1){1'b0}}, mark_reg};
        end
    end

    assign cfg.rebase_offset = shift_reg;
    assign cfg.live_mark     = mark_reg;

endmodule

FILE: sv/hipr_in_reg.sv
// Input register of the relocator: holds one request from the s_ side.
// Depends on hipr_pkg.
module hipr_in_reg (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  hipr_pkg::item_t s_item,
    output logic            item_valid,
    output hipr_pkg::item_t item,
    input  logic            item_take
);

    logic            valid_reg;
    logic            valid_next;
    hipr_pkg::item_t item_reg;

    assign s_ready    = !valid_reg || item_take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !item_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: sv/hipr_parser.sv
// Object layout parser and pointer rebasing for one heap word per cycle while step is high.
// Depends on hipr_pkg.
module hipr_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  hipr_pkg::item_t   item,
    input  hipr_pkg::cfg_t    cfg,
    output hipr_pkg::result_t result
);

    hipr_pkg::phase_t               phase_reg, phase_next;
    logic [hipr_pkg::COUNT_W-1:0]   slots_reg, slots_next;
    logic [hipr_pkg::PAY_W-1:0]     pwl_reg, pwl_next;
    logic [hipr_pkg::BYTES_W-1:0]   pend_reg, pend_next;
    logic                           live_reg, live_next;
    logic                           ptr_reg, ptr_next;

    logic [hipr_pkg::WORD_W-1:0]    w;
    logic [1:0]                     hdr_type;
    logic [hipr_pkg::COUNT_W-1:0]   hdr_count;
    logic [hipr_pkg::HASH_W-1:0]    hdr_hash;
    logic [hipr_pkg::BYTES_W:0]     pend_round;
    logic [hipr_pkg::PAY_W-1:0]     hdr_pw;
    logic [hipr_pkg::COUNT_W-1:0]   slots_dec;
    logic [hipr_pkg::PAY_W-1:0]     pwl_dec;
    logic                           zero_size;
    logic                           untagged;

    assign w          = item.heap_word;
    assign hdr_type   = w[31:30];
    assign hdr_count  = w[29:24];
    assign hdr_hash   = w[23:1];
    assign pend_round = {1'b0, pend_reg} + (hipr_pkg::BYTES_W+1)'(hipr_pkg::WORD_BYTES - 1);
    assign hdr_pw     = (hdr_type != hipr_pkg::TYPE_PLAIN)
                        ? pend_round[hipr_pkg::BYTES_W:hipr_pkg::WORD_SHIFT] : '0;
    assign slots_dec  = (slots_reg != '0) ? slots_reg - (hipr_pkg::COUNT_W)'(1) : slots_reg;
    assign pwl_dec    = (pwl_reg != '0) ? pwl_reg - (hipr_pkg::PAY_W)'(1) : pwl_reg;
    assign zero_size  = (hdr_count == '0) && (hdr_pw == '0);
    assign untagged   = !w[0];

    // next state
    always_comb begin
        phase_next = phase_reg;
        slots_next = slots_reg;
        pwl_next   = pwl_reg;
        pend_next  = pend_reg;
        live_next  = live_reg;
        ptr_next   = ptr_reg;
        case (phase_reg)
            hipr_pkg::PH_HEADER: begin
                if (hdr_type == hipr_pkg::TYPE_PAY_HDR) begin
                    pend_next = w[hipr_pkg::BYTES_W-1:0];
                end else begin
                    pend_next = '0;
                    live_next = (w[0] == cfg.live_mark) && (hdr_hash < hipr_pkg::HASH_RESERVED);
                    ptr_next  = (hdr_type == hipr_pkg::TYPE_OOP_ARR);
                    pwl_next  = hdr_pw;
                    if (zero_size) begin
                        slots_next = '0;
                        phase_next = hipr_pkg::PH_HEADER;
                    end else if (hdr_count >= 2) begin
                        slots_next = hdr_count - (hipr_pkg::COUNT_W)'(2);
                        phase_next = hipr_pkg::PH_MAP;
                    end else begin
                        slots_next = '0;
                        phase_next = (hdr_pw != '0) ? hipr_pkg::PH_PAYLOAD : hipr_pkg::PH_HEADER;
                    end
                end
            end
            hipr_pkg::PH_MAP: begin
                if (slots_reg != '0) begin
                    phase_next = hipr_pkg::PH_SLOTS;
                end else begin
                    phase_next = (pwl_reg != '0) ? hipr_pkg::PH_PAYLOAD : hipr_pkg::PH_HEADER;
                end
            end
            hipr_pkg::PH_SLOTS: begin
                slots_next = slots_dec;
                if (slots_dec == '0) begin
                    phase_next = (pwl_reg != '0) ? hipr_pkg::PH_PAYLOAD : hipr_pkg::PH_HEADER;
                end
            end
            hipr_pkg::PH_PAYLOAD: begin
                pwl_next = pwl_dec;
                if (pwl_dec == '0) begin
                    phase_next = hipr_pkg::PH_HEADER;
                end
            end
            default: begin
                phase_next = hipr_pkg::PH_HEADER;
            end
        endcase
        // end of image drops any unfinished object
        if (item.last_word) begin
            phase_next = hipr_pkg::PH_HEADER;
            slots_next = '0;
            pwl_next   = '0;
            pend_next  = '0;
            live_next  = 1'b0;
            ptr_next   = 1'b0;
        end
    end

    // outputs
    always_comb begin
        result.out_word     = w;
        result.was_adjusted = 1'b0;
        result.word_role    = hipr_pkg::ROLE_PAY_HDR;
        result.size_error   = 1'b0;
        result.end_of_image = item.last_word;
        case (phase_reg)
            hipr_pkg::PH_HEADER: begin
                if (hdr_type != hipr_pkg::TYPE_PAY_HDR) begin
                    result.word_role  = hipr_pkg::ROLE_OBJ_HDR;
                    result.size_error = zero_size;
                end
            end
            hipr_pkg::PH_MAP: begin
                result.word_role    = hipr_pkg::ROLE_MAP;
                result.was_adjusted = live_reg;
            end
            hipr_pkg::PH_SLOTS: begin
                result.word_role    = hipr_pkg::ROLE_SLOT;
                result.was_adjusted = live_reg && untagged;
            end
            hipr_pkg::PH_PAYLOAD: begin
                if (ptr_reg) begin
                    result.word_role    = hipr_pkg::ROLE_OOP_ELEM;
                    result.was_adjusted = live_reg && untagged;
                end else begin
                    result.word_role = hipr_pkg::ROLE_BYTE;
                end
            end
            default: begin
                result.word_role = hipr_pkg::ROLE_PAY_HDR;
            end
        endcase
        if (result.was_adjusted) begin
            result.out_word = w + cfg.rebase_offset;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= hipr_pkg::PH_HEADER;
            slots_reg <= '0;
            pwl_reg   <= '0;
            pend_reg  <= '0;
            live_reg  <= 1'b0;
            ptr_reg   <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            slots_reg <= slots_next;
            pwl_reg   <= pwl_next;
            pend_reg  <= pend_next;
            live_reg  <= live_next;
            ptr_reg   <= ptr_next;
        end
    end

endmodule

FILE: sv/hipr_out_reg.sv
// Result register of the relocator: holds one request for the m_ side.
// Depends on hipr_pkg.
module hipr_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              res_valid,
    output logic              res_ready,
    input  hipr_pkg::result_t res,
    output logic              m_valid,
    input  logic              m_ready,
    output hipr_pkg::result_t m_res
);

    logic              valid_reg;
    logic              valid_next;
    hipr_pkg::result_t res_reg;

    assign res_ready  = !valid_reg || m_ready;
    assign valid_next = (res_valid && res_ready) || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

FILE: sv/heap_image_pointer_relocator.sv
// Heap image pointer relocator: one heap word per cycle, each word passes an input
// register, the layout parser with its rebasing adder, and a result register, so a
// result is offered on m_ once its word has passed both registers. Throughput is one word
// per clock, set by the parser state update; back-pressure on m_ stalls s_.
// A word flagged last restarts parsing at a header. Configuration writes (shift at
// byte address 0, mark color at 8) belong between images, while the block is empty.
// Depends on hipr_pkg, hipr_cfg, hipr_in_reg, hipr_parser, hipr_out_reg.
module heap_image_pointer_relocator (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hipr_pkg::ADDR_W-1:0] paddr,
    input  logic [hipr_pkg::WORD_W-1:0] pwdata,
    output logic [hipr_pkg::WORD_W-1:0] prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [hipr_pkg::WORD_W-1:0] s_heap_word,
    input  logic                        s_last_word,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [hipr_pkg::WORD_W-1:0] m_out_word,
    output logic                        m_was_adjusted,
    output logic [2:0]                  m_word_role,
    output logic                        m_size_error,
    output logic                        m_end_of_image
);

    hipr_pkg::cfg_t    cfg;
    hipr_pkg::item_t   s_item;
    hipr_pkg::item_t   item;
    hipr_pkg::result_t res;
    hipr_pkg::result_t m_res;
    logic              item_valid;
    logic              res_ready;
    logic              step;

    assign s_item.heap_word = s_heap_word;
    assign s_item.last_word = s_last_word;
    assign step             = item_valid && res_ready;

    hipr_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hipr_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (res_ready)
    );

    hipr_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (item),
        .cfg     (cfg),
        .result  (res)
    );

    hipr_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (item_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_out_word     = m_res.out_word;
    assign m_was_adjusted = m_res.was_adjusted;
    assign m_word_role    = m_res.word_role;
    assign m_size_error   = m_res.size_error;
    assign m_end_of_image = m_res.end_of_image;

endmodule
